@@ rtl/set_assoc_lru_tag_store_assert.svh @@
// Assertion macros shared by the tag store RTL.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef SET_ASSOC_LRU_TAG_STORE_ASSERT_SVH
`define SET_ASSOC_LRU_TAG_STORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SALRU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SALRU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/salru_pkg.sv @@
// Types and constants of the set-associative LRU tag store.
// No dependencies; imported by salru_way_unit and the top level.
`timescale 1ns / 1ps

package salru_pkg;

    localparam int ADDR_W = 32;
    localparam int CNT_W  = 32;
    localparam int LAT_W  = 5;
    localparam int OUT_W  = 72;  // hit + latency + two counters, padded to bytes

    localparam logic [LAT_W-1:0] LAT_HIT  = 5'd10;
    localparam logic [LAT_W-1:0] LAT_MISS = 5'd20;

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_PROBE  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_UPDATE,
        ST_WRITE,
        ST_DONE
    } state_t;

    // compare flags from the shared way unit
    typedef struct packed {
        logic tag_match;
        logic age_ge;
    } way_cmp_t;

endpackage

@@ rtl/salru_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module salru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/salru_way_unit.sv @@
// Shared per-way unit: tag compare, age compare and LRU age step.
// Depends on salru_pkg.
`timescale 1ns / 1ps

module salru_way_unit #(
    parameter int TAGW = 19,
    parameter int AGEW = 2
) (
    input  logic [TAGW-1:0]   cur_tag,
    input  logic [TAGW-1:0]   way_tag,
    input  logic              way_valid,
    input  logic [AGEW-1:0]   way_age,
    input  logic [AGEW-1:0]   best_age,
    input  logic [AGEW-1:0]   ref_age,
    input  logic              inc_all,
    input  logic              is_target,
    output salru_pkg::way_cmp_t cmp,
    output logic [AGEW-1:0]   age_next
);

    import salru_pkg::*;

    always_comb
    begin
        cmp.tag_match = way_valid && (way_tag == cur_tag);
        cmp.age_ge    = (way_age >= best_age);
        if (is_target)
        begin
            age_next = '0;
        end
        else if (inc_all || (way_age < ref_age))
        begin
            age_next = AGEW'(way_age + 1'b1);
        end
        else
        begin
            age_next = way_age;
        end
    end

endmodule

@@ rtl/set_assoc_lru_tag_store.sv @@
// Top level of the set-associative tag store with true LRU replacement.
// Depends on salru_pkg, salru_ram, salru_way_unit and the assertion header.
`timescale 1ns / 1ps
`include "set_assoc_lru_tag_store_assert.svh"

// Usage:
//  Input stream s_*: s_tdata carries the byte address, s_tuser the opcode
//  (0 = access, counted and allocating; 1 = probe, LRU update on hit only).
//  Output stream m_*: one item per input item with hit flag, latency code
//  (10 hit / 20 miss) and the running access and miss counts.
//  Each set is one RAM row holding tag, valid and age for every way.
//  An item walks through: row read, tag/age scan over the ways with one
//  shared compare unit, age update over the ways, row write-back, result
//  load. A probe miss skips update and write-back. A new item is taken only
//  after the last one has finished; s_tready is high only between items.
//  After reset a clearing pass writes every set row; s_tready stays low
//  until it ends. Counters reset to 0.
//  The result sits in an output register: the next item is accepted while
//  it waits; if the receiver still stalls when that item finishes, the
//  block holds in its last step until m_tready frees the register.
module set_assoc_lru_tag_store #(
    parameter int WAYS        = 4,
    parameter int INDEX_BITS  = 8,
    parameter int OFFSET_BITS = 5
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [salru_pkg::ADDR_W-1:0]    s_tdata,   // [31:0] address
    input  logic                            s_tuser,   // [0] opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [salru_pkg::OUT_W-1:0]     m_tdata    // [0] hit, [5:1] latency_code,
                                                       // [37:6] access_total,
                                                       // [69:38] miss_total, rest 0
);

    import salru_pkg::*;

    localparam int SETS    = 1 << INDEX_BITS;
    localparam int AW      = (INDEX_BITS > 0) ? INDEX_BITS : 1;
    localparam int TAG_LSB = OFFSET_BITS + INDEX_BITS;
    localparam int TAGW    = ADDR_W - TAG_LSB;
    localparam int WIDX    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENTRY_W = TAGW + 1 + WIDX;          // {age, valid, tag}
    localparam int ROW_W   = WAYS * ENTRY_W;
    localparam logic [AW-1:0]   SET_MASK = AW'(SETS - 1);
    localparam logic [WIDX-1:0] LAST_WAY = WIDX'(WAYS - 1);

    // control state
    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_idx_reg, clr_idx_next;
    logic            m_valid_reg, m_valid_next;
    logic [CNT_W-1:0] acc_cnt_reg, acc_cnt_next;
    logic [CNT_W-1:0] miss_cnt_reg, miss_cnt_next;

    // item payload and working row
    logic [AW-1:0]   set_reg, set_next;
    logic [TAGW-1:0] tag_reg, tag_next;
    logic            op_reg, op_next;
    logic [WIDX-1:0] way_reg, way_next;
    logic            hit_reg, hit_next;
    logic [WIDX-1:0] hit_way_reg, hit_way_next;
    logic [WIDX-1:0] ref_age_reg, ref_age_next;
    logic [WIDX-1:0] best_age_reg, best_age_next;
    logic [WIDX-1:0] pick_reg, pick_next;
    logic [WIDX-1:0] target_reg, target_next;
    logic            inc_all_reg, inc_all_next;
    logic            m_hit_reg, m_hit_next;
    logic [TAGW-1:0] row_tag_reg  [WAYS];
    logic [TAGW-1:0] row_tag_next [WAYS];
    logic            row_vld_reg  [WAYS];
    logic            row_vld_next [WAYS];
    logic [WIDX-1:0] row_age_reg  [WAYS];
    logic [WIDX-1:0] row_age_next [WAYS];

    // RAM and unit hookup
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] reset_row;
    logic [ROW_W-1:0] work_row;
    logic [ADDR_W-1:0] addr_shift;
    way_cmp_t         cmp;
    logic [WIDX-1:0]  unit_age_next;

    assign addr_shift = s_tdata >> OFFSET_BITS;
    assign ram_raddr  = addr_shift[AW-1:0] & SET_MASK;
    assign ram_re     = s_tvalid && s_tready;

    // row images: reset ages are a descending permutation, tags zero
    always_comb
    begin
        for (int j = 0; j < WAYS; j++)
        begin
            reset_row[j*ENTRY_W +: ENTRY_W] = {WIDX'(WAYS - 1 - j), 1'b0, TAGW'(0)};
            work_row[j*ENTRY_W +: ENTRY_W]  = {row_age_reg[j], row_vld_reg[j], row_tag_reg[j]};
        end
    end

    salru_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    salru_way_unit #(
        .TAGW (TAGW),
        .AGEW (WIDX)
    ) u_way_unit (
        .cur_tag   (tag_reg),
        .way_tag   (row_tag_reg[way_reg]),
        .way_valid (row_vld_reg[way_reg]),
        .way_age   (row_age_reg[way_reg]),
        .best_age  (best_age_reg),
        .ref_age   (ref_age_reg),
        .inc_all   (inc_all_reg),
        .is_target (way_reg == target_reg),
        .cmp       (cmp),
        .age_next  (unit_age_next)
    );

    always_comb
    begin
        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        m_valid_next  = m_valid_reg;
        acc_cnt_next  = acc_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        set_next      = set_reg;
        tag_next      = tag_reg;
        op_next       = op_reg;
        way_next      = way_reg;
        hit_next      = hit_reg;
        hit_way_next  = hit_way_reg;
        ref_age_next  = ref_age_reg;
        best_age_next = best_age_reg;
        pick_next     = pick_reg;
        target_next   = target_reg;
        inc_all_next  = inc_all_reg;
        m_hit_next    = m_hit_reg;
        row_tag_next  = row_tag_reg;
        row_vld_next  = row_vld_reg;
        row_age_next  = row_age_reg;
        s_tready      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = set_reg;
        ram_wdata     = work_row;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_idx_reg;
                ram_wdata    = reset_row;
                clr_idx_next = AW'(clr_idx_reg + 1'b1);
                if (clr_idx_reg == SET_MASK)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    set_next   = ram_raddr;
                    tag_next   = TAGW'(s_tdata >> TAG_LSB);
                    op_next    = s_tuser;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                for (int j = 0; j < WAYS; j++)
                begin
                    {row_age_next[j], row_vld_next[j], row_tag_next[j]} =
                        ram_rdata[j*ENTRY_W +: ENTRY_W];
                end
                way_next      = '0;
                hit_next      = 1'b0;
                best_age_next = '0;
                pick_next     = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                // first matching way wins; last way with the top age is the victim
                if (!hit_reg && cmp.tag_match)
                begin
                    hit_next     = 1'b1;
                    hit_way_next = way_reg;
                    ref_age_next = row_age_reg[way_reg];
                end
                if (cmp.age_ge)
                begin
                    best_age_next = row_age_reg[way_reg];
                    pick_next     = way_reg;
                end
                way_next = WIDX'(way_reg + 1'b1);
                if (way_reg == LAST_WAY)
                begin
                    way_next     = '0;
                    target_next  = hit_next ? hit_way_next : pick_next;
                    inc_all_next = !hit_next;
                    if (hit_next || (op_reg == OP_ACCESS))
                    begin
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_UPDATE:
            begin
                row_age_next[way_reg] = unit_age_next;
                if (!hit_reg && (way_reg == target_reg))
                begin
                    row_tag_next[way_reg] = tag_reg;
                    row_vld_next[way_reg] = 1'b1;
                end
                way_next = WIDX'(way_reg + 1'b1);
                if (way_reg == LAST_WAY)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                ram_we     = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_hit_next   = hit_reg;
                    if (op_reg == OP_ACCESS)
                    begin
                        acc_cnt_next = CNT_W'(acc_cnt_reg + 1'b1);
                        if (!hit_reg)
                        begin
                            miss_cnt_next = CNT_W'(miss_cnt_reg + 1'b1);
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_idx_reg  <= '0;
            m_valid_reg  <= 1'b0;
            acc_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            m_valid_reg  <= m_valid_next;
            acc_cnt_reg  <= acc_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_reg      <= set_next;
        tag_reg      <= tag_next;
        op_reg       <= op_next;
        way_reg      <= way_next;
        hit_reg      <= hit_next;
        hit_way_reg  <= hit_way_next;
        ref_age_reg  <= ref_age_next;
        best_age_reg <= best_age_next;
        pick_reg     <= pick_next;
        target_reg   <= target_next;
        inc_all_reg  <= inc_all_next;
        m_hit_reg    <= m_hit_next;
        row_tag_reg  <= row_tag_next;
        row_vld_reg  <= row_vld_next;
        row_age_reg  <= row_age_next;
    end

    // counters always hold the totals of the item on display
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, miss_cnt_reg, acc_cnt_reg,
                       (m_hit_reg ? LAT_HIT : LAT_MISS), m_hit_reg};

    `SALRU_ASSERT_NXT(a_accept_loads, s_tvalid && s_tready, state_reg == ST_LOAD,
                      "accepted item did not start a row read")
    `SALRU_ASSERT_IMP(a_ram_write_state, ram_we,
                      state_reg == ST_CLEAR || state_reg == ST_WRITE,
                      "row RAM written outside clear or write-back")
    `SALRU_ASSERT_IMP(a_result_from_done, $rose(m_valid_reg), $past(state_reg) == ST_DONE,
                      "result appeared without a finished item")
    `SALRU_ASSERT_IMP(a_miss_counts_access, !$stable(miss_cnt_reg), !$stable(acc_cnt_reg),
                      "miss counted without an access")

endmodule
